// ----- rtl/bffca_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bffca_pkg;

    localparam int NUM_CHUNKS   = 4096;
    localparam int CHUNK_BYTES  = 32;
    localparam int HEADER_BYTES = 4;
    localparam int GROUP_SIZE   = 8;

    localparam int NUM_GROUPS   = NUM_CHUNKS / GROUP_SIZE;
    localparam int CHUNK_W      = $clog2(NUM_CHUNKS);
    localparam int GROUP_W      = $clog2(NUM_GROUPS);
    localparam int BIT_W        = $clog2(GROUP_SIZE);
    localparam int CHUNK_SHIFT  = $clog2(CHUNK_BYTES);

    localparam int REQ_W        = 20;
    localparam int OFFSET_W     = 17;
    localparam int LEN_W        = 13;
    localparam int FREE_W       = 18;
    localparam int UG_W         = 10;
    localparam int REAL_W       = REQ_W + 1;

    localparam logic [UG_W-1:0] USABLE_GROUPS_RESET = UG_W'(512);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef struct packed {
        logic                func;
        logic [REQ_W-1:0]    request_bytes;
        logic [OFFSET_W-1:0] release_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFFSET_W-1:0] block_offset;
        logic [LEN_W-1:0]    granted_chunks;
        logic [FREE_W-1:0]   free_bytes;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0]   run;
        logic [CHUNK_W-1:0] first;
    } t_scan_state;

    typedef struct packed {
        logic               hit;
        logic [CHUNK_W-1:0] hit_first;
        t_scan_state        next;
    } t_scan_res;

endpackage
`default_nettype wire

// ----- rtl/bffca_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bffca_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/bffca_group_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bffca_group_scan
    import bffca_pkg::*;
(
    input  wire logic [GROUP_SIZE-1:0] i_bits,
    input  wire logic [GROUP_W-1:0]    i_group,
    input  wire logic [LEN_W-1:0]      i_need,
    input  wire t_scan_state           i_state,
    output t_scan_res                  o_res
);

    // Walk one group low bit first, carrying the free run across groups.
    always_comb begin
        logic [LEN_W-1:0]   run;
        logic [CHUNK_W-1:0] first;
        logic [CHUNK_W-1:0] c;
        run   = i_state.run;
        first = i_state.first;
        o_res = '0;
        for (int b = 0; b < GROUP_SIZE; b++) begin
            c = {i_group, BIT_W'(b)};
            if (i_bits[b]) begin
                run = '0;
            end else begin
                if (run == '0) begin
                    first = c;
                end
                run = run + LEN_W'(1);
                if (!o_res.hit && run == i_need) begin
                    o_res.hit       = 1'b1;
                    o_res.hit_first = first;
                end
            end
        end
        o_res.next.run   = run;
        o_res.next.first = first;
    end

endmodule
`default_nettype wire

// ----- rtl/bitmap_first_fit_chunk_allocator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Allocate: scan the usage map group by group (up to 512), then read and write each group marked.
// Free: look up the run length, then read and write each group cleared; bad requests skip the marking.
// One item at a time: the single-port usage map (one group per access) sets the rate.
// After reset a clearing pass zeroes both memories; no item is taken.
// Configuration writes are taken at any time, including during the clearing pass.
module bitmap_first_fit_chunk_allocator_core
    import bffca_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire t_in_item        i_in_item,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out_item            o_out_item,
    input  wire logic            i_cfg_we,
    input  wire logic [UG_W-1:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_CHK,
        S_MARK_RD,
        S_MARK_WR,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [CHUNK_W-1:0]  r_cnt;
    logic [UG_W-1:0]     r_ug;
    logic [LEN_W-1:0]    r_alloc;
    logic                r_func;
    logic [OFFSET_W-1:0] r_off;
    logic [LEN_W-1:0]    r_need;
    logic [CHUNK_W-1:0]  r_first;
    logic [CHUNK_W-1:0]  r_hi;
    logic [GROUP_W-1:0]  r_grp;
    logic [LEN_W-1:0]    r_run;
    t_status             r_status;

    // Pool size: saturate the group count, then work out free space.
    logic [UG_W-1:0]   pool_groups;
    logic [LEN_W-1:0]  pool_chunks;
    logic [FREE_W-1:0] free_bytes;
    logic [LEN_W-1:0]  free_chunks;

    always_comb begin
        pool_groups = (r_ug > UG_W'(NUM_GROUPS)) ? UG_W'(NUM_GROUPS) : r_ug;
        pool_chunks = LEN_W'({pool_groups, {BIT_W{1'b0}}});
        free_chunks = (r_alloc >= pool_chunks) ? '0 : (pool_chunks - r_alloc);
        free_bytes  = FREE_W'({free_chunks, {CHUNK_SHIFT{1'b0}}});
    end

    // Request decode: header added, rounded up to whole chunks.
    logic [REAL_W-1:0]        real_bytes;
    logic [REAL_W-1:0]        real_round;
    logic [REAL_W-CHUNK_SHIFT-1:0] need_full;
    logic [OFFSET_W-1:0]      rel_off;
    logic                     free_bad;

    always_comb begin
        real_bytes = REAL_W'(i_in_item.request_bytes) + REAL_W'(HEADER_BYTES);
        real_round = real_bytes + REAL_W'(CHUNK_BYTES - 1);
        need_full  = real_round[REAL_W-1:CHUNK_SHIFT];
        rel_off    = i_in_item.release_offset - OFFSET_W'(HEADER_BYTES);
        free_bad   = (i_in_item.release_offset < OFFSET_W'(HEADER_BYTES))
                  || (rel_off[CHUNK_SHIFT-1:0] != '0);
    end

    // Usage map: one group of eight bits per entry.
    logic                   map_we;
    logic [GROUP_W-1:0]     map_addr;
    logic [GROUP_SIZE-1:0]  map_wdata;
    logic [GROUP_SIZE-1:0]  map_rdata;
    logic [GROUP_SIZE-1:0]  mark_mask;

    // Run length table: one entry per chunk, keyed by start chunk.
    logic                   len_we;
    logic [CHUNK_W-1:0]     len_addr;
    logic [LEN_W-1:0]       len_wdata;
    logic [LEN_W-1:0]       len_rdata;

    logic                   last_mark;

    always_comb begin
        logic [CHUNK_W-1:0] c;
        for (int b = 0; b < GROUP_SIZE; b++) begin
            c = {r_grp, BIT_W'(b)};
            mark_mask[b] = (c >= r_first) && (c <= r_hi);
        end
        last_mark = (r_grp == r_hi[CHUNK_W-1:BIT_W]);
    end

    always_comb begin
        map_we    = 1'b0;
        map_addr  = r_grp;
        map_wdata = '0;
        len_we    = 1'b0;
        len_addr  = r_first;
        len_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                map_we   = 1'b1;
                map_addr = r_cnt[GROUP_W-1:0];
                len_we   = 1'b1;
                len_addr = r_cnt;
            end
            S_IDLE: begin
                map_addr = '0;
                len_addr = rel_off[OFFSET_W-1:CHUNK_SHIFT];
            end
            S_SCAN: begin
                // prefetch the next group while this one is examined
                map_addr = r_grp + GROUP_W'(1);
            end
            S_MARK_WR: begin
                map_we    = 1'b1;
                map_wdata = (r_func == FUNC_ALLOC) ? (map_rdata | mark_mask)
                                                   : (map_rdata & ~mark_mask);
                len_we    = last_mark;
                len_wdata = (r_func == FUNC_ALLOC) ? r_need : '0;
            end
            default: begin
            end
        endcase
    end

    bffca_ram #(
        .WIDTH (GROUP_SIZE),
        .DEPTH (NUM_GROUPS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_addr  (map_addr),
        .i_wdata (map_wdata),
        .o_rdata (map_rdata)
    );

    bffca_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_CHUNKS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_addr  (len_addr),
        .i_wdata (len_wdata),
        .o_rdata (len_rdata)
    );

    t_scan_res scan_res;

    bffca_group_scan u_scan (
        .i_bits  (map_rdata),
        .i_group (r_grp),
        .i_need  (r_need),
        .i_state ({r_run, r_first}),
        .o_res   (scan_res)
    );

    // End of run, clamped to the last chunk.
    logic [LEN_W-1:0]   alloc_end;
    logic [LEN_W-1:0]   free_end;
    logic [CHUNK_W-1:0] alloc_hi;
    logic [CHUNK_W-1:0] free_hi;

    always_comb begin
        alloc_end = LEN_W'(scan_res.hit_first) + r_need - LEN_W'(1);
        free_end  = LEN_W'(r_first) + len_rdata - LEN_W'(1);
        alloc_hi  = alloc_end[CHUNK_W] ? '1 : alloc_end[CHUNK_W-1:0];
        free_hi   = free_end[CHUNK_W] ? '1 : free_end[CHUNK_W-1:0];
    end

    logic out_free;
    assign out_free   = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_ug        <= USABLE_GROUPS_RESET;
            r_alloc     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ug <= i_cfg_wdata;
            end
            // drop a taken result; the finish state reloads the register itself
            if (o_out_valid && !i_out_stall && r_state != S_FINISH) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + CHUNK_W'(1);
                    if (r_cnt == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func <= i_in_item.func;
                        r_off  <= i_in_item.release_offset;
                        r_run  <= '0;
                        r_grp  <= '0;
                        if (i_in_item.func == FUNC_ALLOC) begin
                            r_need <= need_full[LEN_W-1:0];
                            if (real_bytes > REAL_W'(free_bytes) || need_full == '0) begin
                                r_status <= ST_OOM;
                                r_state  <= S_FINISH;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_first <= rel_off[OFFSET_W-1:CHUNK_SHIFT];
                            if (free_bad) begin
                                r_status <= ST_BAD_FREE;
                                r_state  <= S_FINISH;
                            end else begin
                                r_state <= S_FREE_CHK;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_run <= scan_res.next.run;
                    if (scan_res.hit) begin
                        r_first <= scan_res.hit_first;
                        r_hi    <= alloc_hi;
                        r_grp   <= scan_res.hit_first[CHUNK_W-1:BIT_W];
                        r_state <= S_MARK_RD;
                    end else begin
                        r_first <= scan_res.next.first;
                        if (UG_W'(r_grp) + UG_W'(1) >= pool_groups) begin
                            r_status <= ST_OOM;
                            r_state  <= S_FINISH;
                        end else begin
                            r_grp <= r_grp + GROUP_W'(1);
                        end
                    end
                end
                S_FREE_CHK: begin
                    if (len_rdata == '0) begin
                        r_status <= ST_BAD_FREE;
                        r_state  <= S_FINISH;
                    end else begin
                        r_need  <= len_rdata;
                        r_hi    <= free_hi;
                        r_grp   <= r_first[CHUNK_W-1:BIT_W];
                        r_state <= S_MARK_RD;
                    end
                end
                S_MARK_RD: begin
                    r_state <= S_MARK_WR;
                end
                S_MARK_WR: begin
                    if (last_mark) begin
                        r_status <= ST_OK;
                        r_state  <= S_FINISH;
                        if (r_func == FUNC_ALLOC) begin
                            r_alloc <= r_alloc + r_need;
                        end else begin
                            r_alloc <= (r_alloc >= r_need) ? (r_alloc - r_need) : '0;
                        end
                    end else begin
                        r_grp   <= r_grp + GROUP_W'(1);
                        r_state <= S_MARK_RD;
                    end
                end
                S_FINISH: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        o_out_valid           <= 1'b1;
                        o_out_item.status     <= r_status;
                        o_out_item.free_bytes <= free_bytes;
                        if (r_status == ST_OK) begin
                            o_out_item.granted_chunks <= r_need;
                            o_out_item.block_offset   <= (r_func == FUNC_ALLOC)
                                ? (OFFSET_W'({r_first, {CHUNK_SHIFT{1'b0}}})
                                   + OFFSET_W'(HEADER_BYTES))
                                : r_off;
                        end else begin
                            o_out_item.granted_chunks <= '0;
                            o_out_item.block_offset   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Errors carry no offset and no chunks.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK)
        |-> (o_out_item.granted_chunks == '0 && o_out_item.block_offset == '0))
        else $error("error result carries payload");

    // Allocated chunks never exceed the chunk count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= LEN_W'(NUM_CHUNKS))
        else $error("allocated chunk count overflow");

    // An accepted item always leaves idle on the next edge.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item not taken up");

    // Marking never walks past the end of its run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK_WR) |-> (r_grp <= r_hi[CHUNK_W-1:BIT_W]))
        else $error("mark walk overran run");

endmodule
`default_nettype wire
